// File: hdl/spf_pkg.sv
// Shared constants and types for the smallest-prime-factor factoriser.
`timescale 1ns / 1ps

package spf_pkg;

   // Widths of the item fields and of the factor table.
   localparam int VALUE_W     = 16;
   localparam int SPF_W       = 8;
   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // Sieve divisors run to the square root of the limit, one bit wider than an entry.
   localparam int D_W  = SPF_W + 1;
   localparam int SQ_W = 2 * D_W;
   localparam int M_W  = VALUE_W + 1;

   localparam int MAX_RESULTS = 15;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int DIV_STEPS = VALUE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [SPF_W-1:0] PRIME_MARK = SPF_W'(1);

   // One access of the factor table: a write port and a read port.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [SPF_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } spf_mem_req_type;

endpackage

// File: hdl/smallest_prime_factor_factorizer.sv
// Top level of the smallest-prime-factor factoriser: sequencer, sieve and factor walk.
// The first item after reset or a limit write clears limit+1 entries, then sieves (the
//   sieve is paced by the single table write port); after that each factor takes a table
//   read, and every factor but the last a divider pass, one item at a time.
// Reset (synchronous, active high) invalidates the table and sets the limit to 65535.
// Results appear for exactly one cycle on rsp_valid; the receiver cannot stall them.
`timescale 1ns / 1ps

module smallest_prime_factor_factorizer
   import spf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               csr_we,
   input  logic [VALUE_W-1:0] csr_wdata,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_factor,
   output logic               rsp_last,
   output logic               rsp_error
);

   // Sequencer states, one-hot.
   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_CLEAR   = 9'b000000010,
      ST_SV_TEST = 9'b000000100,
      ST_SV_READ = 9'b000001000,
      ST_SV_RUN  = 9'b000010000,
      ST_CHECK   = 9'b000100000,
      ST_FACT_RD = 9'b001000000,
      ST_LOOK    = 9'b010000000,
      ST_DIVIDE  = 9'b100000000
   } state_type;

   // The limit register saturates at the last table entry.
   function automatic logic [VALUE_W-1:0] clamp_limit(input logic [VALUE_W-1:0] x);
      logic [VALUE_W:0] top_index;
      top_index = (VALUE_W + 1)'(TABLE_DEPTH - 1);
      if ({1'b0, x} > top_index) begin
         return top_index[VALUE_W-1:0];
      end
      return x;
   endfunction

   state_type          state_ff,       state_in;
   logic               ready_ff,       ready_in;
   logic [VALUE_W-1:0] lim_ff,         lim_in;
   logic [VALUE_W-1:0] value_ff,       value_in;
   logic [CNT_W-1:0]   count_ff,       count_in;
   logic [D_W-1:0]     d_ff,           d_in;
   logic [SQ_W-1:0]    sq_ff,          sq_in;
   logic [M_W-1:0]     m_ff,           m_in;
   logic               pend_ff,        pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff,   pend_addr_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   logic [VALUE_W-1:0] rsp_factor_ff,  rsp_factor_in;
   logic               rsp_last_ff,    rsp_last_in;
   logic               rsp_error_ff,   rsp_error_in;

   spf_mem_req_type    mem_req;
   logic [SPF_W-1:0]   mem_rdata;
   logic               div_start;
   logic               div_done;
   logic [VALUE_W-1:0] div_quotient;

   spf_table_ram u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   spf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (mem_rdata),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in      = state_ff;
      ready_in      = ready_ff;
      lim_in        = lim_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      m_in          = m_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_factor_in = rsp_factor_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_error_in  = rsp_error_ff;
      mem_req       = '0;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               count_in = '0;
               if (ready_ff) begin
                  state_in = ST_CHECK;
               end else begin
                  m_in     = '0;
                  state_in = ST_CLEAR;
               end
            end
         end

         // Put the prime mark into every entry from zero up to the limit.
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = m_ff[ADDR_W-1:0];
            mem_req.wdata = PRIME_MARK;
            if (m_ff == {1'b0, lim_ff}) begin
               d_in     = D_W'(2);
               state_in = ST_SV_TEST;
            end else begin
               m_in = m_ff + M_W'(1);
            end
         end

         // Stop once the square of the divisor passes the limit; otherwise look it up.
         ST_SV_TEST: begin
            sq_in = d_ff * d_ff;
            if (sq_in > SQ_W'(lim_ff)) begin
               ready_in = 1'b1;
               state_in = ST_CHECK;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = ADDR_W'(d_ff);
               state_in      = ST_SV_READ;
            end
         end

         // Only divisors still carrying the prime mark strike out their multiples.
         ST_SV_READ: begin
            if (mem_rdata == PRIME_MARK) begin
               m_in     = sq_ff[M_W-1:0];
               pend_in  = 1'b0;
               state_in = ST_SV_RUN;
            end else begin
               d_in     = d_ff + D_W'(1);
               state_in = ST_SV_TEST;
            end
         end

         // A read of the next multiple is issued each cycle while the entry read in the
         // previous cycle is written back if it still holds the prime mark. The two addresses
         // always differ by the divisor, so no access can hit an entry whose update is still outstanding.
         ST_SV_RUN: begin
            if (pend_ff && (mem_rdata == PRIME_MARK)) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pend_addr_ff;
               mem_req.wdata = d_ff[SPF_W-1:0];
            end
            if (m_ff <= {1'b0, lim_ff}) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = m_ff[ADDR_W-1:0];
               pend_in       = 1'b1;
               pend_addr_in  = m_ff[ADDR_W-1:0];
               m_in          = m_ff + M_W'(d_ff);
            end else begin
               pend_in  = 1'b0;
               d_in     = d_ff + D_W'(1);
               state_in = ST_SV_TEST;
            end
         end

         // Zero and values past the limit give a single error item.
         ST_CHECK: begin
            if ((value_ff == '0) || (value_ff > lim_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_factor_in = '0;
               rsp_last_in   = 1'b1;
               rsp_error_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_FACT_RD;
            end
         end

         ST_FACT_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = value_ff[ADDR_W-1:0];
            state_in      = ST_LOOK;
         end

         // A prime mark means the remaining value is itself the last factor.
         ST_LOOK: begin
            rsp_valid_in = 1'b1;
            rsp_error_in = 1'b0;
            if (mem_rdata < SPF_W'(2)) begin
               rsp_factor_in = value_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rsp_factor_in = VALUE_W'(mem_rdata);
               rsp_last_in   = 1'b0;
               count_in      = count_ff + CNT_W'(1);
               if (count_ff == CNT_W'(MAX_RESULTS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end
            end
         end

         ST_DIVIDE: begin
            if (div_done) begin
               value_in = div_quotient;
               state_in = ST_FACT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A limit write must come only while idle, which the block does not enforce; it forces a fresh sieve.
      if (csr_we) begin
         lim_in   = clamp_limit(csr_wdata);
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b0;
         lim_ff       <= clamp_limit({VALUE_W{1'b1}});
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         lim_ff       <= lim_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff      <= value_in;
      d_ff          <= d_in;
      sq_ff         <= sq_in;
      m_ff          <= m_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = rsp_factor_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_error_ff;

`ifndef SYNTHESIS
   // An error item always closes its item's results.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error result without last");

   // Nothing follows the last result in the very next cycle.
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result straight after last");

   // Write-back and look-ahead read never touch the same entry.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      mem_req.we && mem_req.re |-> mem_req.waddr != mem_req.raddr)
      else $error("table read and write to the same entry");

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting an item");
`endif

endmodule

// File: hdl/spf_table_ram.sv
// Factor table: simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module spf_table_ram
   import spf_pkg::*;
(
   input  logic             clock,
   input  spf_mem_req_type  mem_req,
   output logic [SPF_W-1:0] rdata
);

   logic [SPF_W-1:0] mem [TABLE_DEPTH];
   logic [SPF_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/spf_divider.sv
// Restoring divider: one quotient bit per cycle, value divided by an 8-bit factor.
`timescale 1ns / 1ps

module spf_divider
   import spf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] dividend,
   input  logic [SPF_W-1:0]   divisor,
   output logic               done,
   output logic [VALUE_W-1:0] quotient
);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [DIV_CNT_W-1:0] step_ff,  step_in;
   logic [VALUE_W-1:0]   quo_ff,   quo_in;
   logic [SPF_W-1:0]     rem_ff,   rem_in;
   logic [SPF_W-1:0]     dsr_ff,   dsr_in;
   logic [SPF_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[VALUE_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = DIV_CNT_W'(DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = SPF_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[VALUE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SPF_W-1:0];
            quo_in = {quo_ff[VALUE_W-2:0], 1'b0};
         end
         step_in = step_ff - DIV_CNT_W'(1);
         if (step_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
